>>> src/bol_pkg.sv
// ----------------------------------------------------------------------------
// bol_pkg: shared types and constants for the bounded ordered list
// Depth, widths, command and status codes, controller state encoding.
// ----------------------------------------------------------------------------
package bol_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned WordW = 32;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_POP_BACK   = 2'd1,
    CMD_INSERT     = 2'd2,
    CMD_FIND       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SCAN_RD  = 6'b000010,
    S_SCAN_CMP = 6'b000100,
    S_SHIFT_RD = 6'b001000,
    S_SHIFT_WR = 6'b010000,
    S_PLACE    = 6'b100000
  } state_e;

endpackage

>>> src/bol_ram.sv
// ----------------------------------------------------------------------------
// bol_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bol_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/bounded_ordered_list_top.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_top: bounded list of signed words, head to tail
// Push front, pop back, ordered insert and find over a RAM-held list.
// ----------------------------------------------------------------------------
// Usage:
//   Drive command_i/value_i and raise start while busy is low; the
//   transaction is taken at that clock edge. Exactly one result follows,
//   shown on status_o/found_o/position_o/count_o for one cycle while
//   done_o is high. The receiver cannot stall; done_o drops after
//   that cycle.
// Steps: pop back, any push to a full list and find on an empty list
// finish straight from idle. Find scans from the head until a match or
// the tail. Ordered insert scans for the first entry not below the value,
// then moves entries up from the tail down to that gap and places the
// value there; push front moves every entry and places at the head.
// Each scan step and each shift step is a read state followed by a
// compare or write state, as the single RAM read port allows.
// A new command may be started in the cycle done_o is high.
// Reset empties the list; entry contents are left as they are.
// ----------------------------------------------------------------------------
module bounded_ordered_list_top
  import bol_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic signed [31:0] value_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic        found_o,
  output logic [3:0]  position_o,
  output logic [4:0]  count_o
);

  state_e state_q, state_d;
  cmd_e   cmd_q, cmd_d;
  word_t  val_q, val_d;
  cnt_t   cnt_q, cnt_d;     // entries held
  cnt_t   idx_q, idx_d;     // scan index
  cnt_t   pos_q, pos_d;     // insert position
  cnt_t   ptr_q, ptr_d;     // shift destination

  logic      done_q, done_d;
  status_e   status_q, status_d;
  logic      found_q, found_d;
  logic [3:0] posout_q, posout_d;

  logic  ram_we;
  addr_t ram_waddr, ram_raddr;
  word_t ram_wdata, ram_rdata;

  logic  hit;
  cnt_t  idx_nxt;
  logic [31:0] idx_wide, cnt_wide;

  bol_ram #(
    .Width (WordW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Compare the entry just read against the search value.
  always_comb begin
    if (cmd_q == CMD_FIND) begin
      hit = (ram_rdata == val_q);
    end else begin
      hit = ($signed(ram_rdata) >= $signed(val_q));
    end
  end

  assign idx_nxt  = idx_q + cnt_t'(1);
  assign idx_wide = 32'(idx_q);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    val_d     = val_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    ptr_d     = ptr_q;
    done_d    = 1'b0;
    status_d  = status_q;
    found_d   = found_q;
    posout_d  = posout_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q[AddrW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_q[AddrW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d    = cmd_e'(command_i);
          val_d    = word_t'(value_i);
          idx_d    = '0;
          pos_d    = '0;
          ptr_d    = cnt_q;
          status_d = ST_DONE;
          found_d  = 1'b0;
          posout_d = '0;
          unique case (cmd_e'(command_i))
            CMD_POP_BACK: begin
              done_d = 1'b1;
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                cnt_d = cnt_q - cnt_t'(1);
              end
            end
            CMD_PUSH_FRONT, CMD_INSERT: begin
              if (cnt_q == cnt_t'(Depth)) begin
                done_d   = 1'b1;
                status_d = ST_FULL;
              end else if (cmd_e'(command_i) == CMD_PUSH_FRONT || cnt_q == '0) begin
                state_d = S_SHIFT_RD;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            CMD_FIND: begin
              if (cnt_q == '0) begin
                done_d = 1'b1;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (hit) begin
          if (cmd_q == CMD_FIND) begin
            done_d   = 1'b1;
            found_d  = 1'b1;
            posout_d = idx_wide[3:0];
            state_d  = S_IDLE;
          end else begin
            pos_d   = idx_q;
            state_d = S_SHIFT_RD;
          end
        end else if (idx_nxt == cnt_q) begin
          if (cmd_q == CMD_FIND) begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            pos_d   = cnt_q;
            state_d = S_SHIFT_RD;
          end
        end else begin
          idx_d   = idx_nxt;
          state_d = S_SCAN_RD;
        end
      end

      // Move entries up by one from the tail down to the gap.
      S_SHIFT_RD: begin
        if (ptr_q == pos_q) begin
          state_d = S_PLACE;
        end else begin
          ram_raddr = AddrW'(ptr_q - cnt_t'(1));
          state_d   = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        ram_we  = 1'b1;
        ptr_d   = ptr_q - cnt_t'(1);
        state_d = S_SHIFT_RD;
      end

      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[AddrW-1:0];
        ram_wdata = val_q;
        cnt_d     = cnt_q + cnt_t'(1);
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    val_q    <= val_d;
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    ptr_q    <= ptr_d;
    status_q <= status_d;
    found_q  <= found_d;
    posout_q <= posout_d;
  end

  assign cnt_wide   = 32'(cnt_q);
  assign busy       = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign status_o   = status_q;
  assign found_o    = found_q;
  assign position_o = posout_q;
  assign count_o    = cnt_wide[4:0];

`ifndef SYNTHESIS
  // A result only ever appears once the controller is back at rest.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");

  // The entry count never exceeds the depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cnt_t'(Depth)) else $error("count above depth");

  // A RAM write never happens at rest.
  a_we_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> busy) else $error("RAM write while idle");

  // The count changes by at most one and only with a result.
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> done_o) else $error("count moved without result");
`endif

endmodule
